/* rtl/vcdac_pkg.sv */
// ----------------------------------------------------------------------------
// vcdac_pkg - video control and palette dac definitions
// Word formats, action and register codes, mode table and reset values.
// ----------------------------------------------------------------------------
package vcdac_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // actions
  localparam logic [2:0] ACT_CTRL_RD = 3'd0;
  localparam logic [2:0] ACT_CTRL_WR = 3'd1;
  localparam logic [2:0] ACT_DAC_RD  = 3'd2;
  localparam logic [2:0] ACT_DAC_WR  = 3'd3;
  localparam logic [2:0] ACT_LOOKUP  = 3'd4;

  // control register offsets
  localparam logic [2:0] CTRL_MODE    = 3'd0;
  localparam logic [2:0] CTRL_DEPTH   = 3'd1;
  localparam logic [2:0] CTRL_MONITOR = 3'd2;
  localparam logic [2:0] CTRL_TEST    = 3'd3;

  // dac register offsets
  localparam logic [1:0] DAC_ADDR = 2'd0;
  localparam logic [1:0] DAC_DATA = 2'd1;
  localparam logic [1:0] DAC_CTRL = 2'd2;
  localparam logic [1:0] DAC_KEY  = 2'd3;

  // palette component lanes
  localparam logic [1:0] LANE_RED   = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;

  // depth codes
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;

  // mode ids
  localparam logic [4:0] MODE_512X384 = 5'h02;
  localparam logic [4:0] MODE_640X480 = 5'h06;
  localparam logic [4:0] MODE_640X870 = 5'h01;
  localparam logic [4:0] MODE_832X624 = 5'h09;
  localparam logic [4:0] MODE_640X480_LOW = 5'h0b;

  localparam logic [7:0] MODE_MASK  = 8'h9f;
  localparam logic [7:0] MODE_RESET = 8'h9f;
  localparam logic [3:0] DRIVE_MASK = 4'hf;
  localparam logic [3:0] DRIVE_RESET = 4'h8;
  localparam logic [2:0] SENSE_RESET = 3'd6;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        display_enabled;
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic [4:0]  bits_per_pixel;
    logic [10:0] stride_bytes;
    logic [23:0] pixel_rgb;
  } out_word_t;

  // result fields produced by the register block, colour comes from the palette
  typedef struct packed {
    logic [7:0]  read_data;
    logic        display_enabled;
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic [4:0]  bits_per_pixel;
    logic [10:0] stride_bytes;
    logic        lookup;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [1:0]        lane;
    logic [7:0]        data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  typedef struct packed {
    logic       known;
    logic       deep;
    logic [9:0] width;
    logic [9:0] height;
  } mode_info_t;

  function automatic mode_info_t mode_decode(input logic [4:0] id);
    mode_info_t mi;
    mi = '0;
    unique case (id)
      MODE_512X384: begin
        mi = '{known: 1'b1, deep: 1'b1, width: 10'd512, height: 10'd384};
      end
      MODE_640X480: begin
        mi = '{known: 1'b1, deep: 1'b1, width: 10'd640, height: 10'd480};
      end
      MODE_640X870: begin
        mi = '{known: 1'b1, deep: 1'b0, width: 10'd640, height: 10'd870};
      end
      MODE_832X624: begin
        mi = '{known: 1'b1, deep: 1'b0, width: 10'd832, height: 10'd624};
      end
      MODE_640X480_LOW: begin
        mi = '{known: 1'b1, deep: 1'b0, width: 10'd640, height: 10'd480};
      end
      default: mi = '0;
    endcase
    return mi;
  endfunction

endpackage

/* rtl/vcdac_regs.sv */
// ----------------------------------------------------------------------------
// vcdac_regs - control and dac register file
// Executes bus operations, decodes the display geometry and issues palette
// reads and component writes.
// ----------------------------------------------------------------------------
module vcdac_regs import vcdac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_word_t   item,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  output res_t       res,
  output pal_wr_t    pal_wr,
  output pal_rd_t    pal_rd
);

  logic [2:0]        monitor_sense;
  logic [7:0]        mode_reg, mode_reg_next;
  logic [2:0]        depth_reg, depth_reg_next;
  logic [3:0]        drive_reg, drive_reg_next;
  logic              test_bit, test_bit_next;
  logic [PAL_AW-1:0] pointer, pointer_next;
  logic [1:0]        component, component_next;
  logic [7:0]        dac_ctrl, dac_ctrl_next;
  logic [7:0]        color_key, color_key_next;

  logic [2:0]  sense_eff;
  logic [7:0]  rd;
  logic        wr_en;
  mode_info_t  mi;
  logic        on;
  logic [13:0] line_bits;
  logic [7:0]  pix_idx;

  assign sense_eff = drive_reg[3] ? monitor_sense : (monitor_sense & drive_reg[2:0]);

  always_comb begin
    mode_reg_next  = mode_reg;
    depth_reg_next = depth_reg;
    drive_reg_next = drive_reg;
    test_bit_next  = test_bit;
    pointer_next   = pointer;
    component_next = component;
    dac_ctrl_next  = dac_ctrl;
    color_key_next = color_key;
    rd             = '0;
    wr_en          = 1'b0;
    unique case (item.action)
      ACT_CTRL_RD: begin
        unique case (item.reg_offset)
          CTRL_MODE:    rd = mode_reg;
          CTRL_DEPTH:   rd = {5'd0, depth_reg};
          CTRL_MONITOR: rd = {1'b0, sense_eff, drive_reg};
          CTRL_TEST:    rd = {7'd0, test_bit};
          default:      rd = '0;
        endcase
      end
      ACT_CTRL_WR: begin
        unique case (item.reg_offset)
          CTRL_MODE:    mode_reg_next  = item.write_data & MODE_MASK;
          CTRL_DEPTH:   depth_reg_next = item.write_data[2:0];
          CTRL_MONITOR: drive_reg_next = item.write_data[3:0] & DRIVE_MASK;
          CTRL_TEST:    test_bit_next  = item.write_data[0];
          default:      ;
        endcase
      end
      ACT_DAC_RD: begin
        if (item.reg_offset[1:0] == DAC_CTRL) rd = dac_ctrl;
      end
      ACT_DAC_WR: begin
        unique case (item.reg_offset[1:0])
          DAC_ADDR: begin
            pointer_next   = item.write_data;
            component_next = LANE_RED;
          end
          DAC_DATA: begin
            wr_en = 1'b1;
            // blue completes the entry and steps the pointer
            if (component >= LANE_BLUE) begin
              component_next = LANE_RED;
              pointer_next   = pointer + 1'b1;
            end else begin
              component_next = component + 1'b1;
            end
          end
          DAC_CTRL: dac_ctrl_next  = item.write_data;
          DAC_KEY:  color_key_next = item.write_data;
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

  // geometry reflects the state after this word's action
  always_comb begin
    mi = mode_decode(mode_reg_next[4:0]);
    on = mi.known && !mode_reg_next[7] && (depth_reg_next < DEPTH_16BPP ||
         (depth_reg_next == DEPTH_16BPP && mi.deep));
    line_bits = {4'd0, mi.width} << depth_reg_next;
    res.read_data       = rd;
    res.display_enabled = on;
    res.frame_width     = on ? mi.width : '0;
    res.frame_height    = on ? mi.height : '0;
    res.bits_per_pixel  = on ? (5'd1 << depth_reg_next) : '0;
    res.stride_bytes    = on ? line_bits[13:3] : '0;
    res.lookup          = on && item.action == ACT_LOOKUP && depth_reg_next < DEPTH_16BPP;
  end

  always_comb begin
    unique case (depth_reg_next)
      DEPTH_1BPP: pix_idx = item.pixel_value[0] ? 8'd127 : 8'd255;
      DEPTH_2BPP: pix_idx = {item.pixel_value[1:0], 6'h3f};
      DEPTH_4BPP: pix_idx = {item.pixel_value[3:0], 4'hf};
      default:    pix_idx = item.pixel_value;
    endcase
  end

  assign pal_rd.en   = accept && res.lookup;
  assign pal_rd.addr = pix_idx[PAL_AW-1:0];
  assign pal_wr.en   = accept && wr_en;
  assign pal_wr.addr = pointer;
  assign pal_wr.lane = component;
  assign pal_wr.data = item.write_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_sense <= SENSE_RESET;
      mode_reg      <= MODE_RESET;
      depth_reg     <= DEPTH_1BPP;
      drive_reg     <= DRIVE_RESET;
      test_bit      <= 1'b0;
      pointer       <= '0;
      component     <= LANE_RED;
      dac_ctrl      <= '0;
      color_key     <= '0;
    end else begin
      if (cfg_wr_en) monitor_sense <= cfg_wr_data;
      if (accept) begin
        mode_reg  <= mode_reg_next;
        depth_reg <= depth_reg_next;
        drive_reg <= drive_reg_next;
        test_bit  <= test_bit_next;
        pointer   <= pointer_next;
        component <= component_next;
        dac_ctrl  <= dac_ctrl_next;
        color_key <= color_key_next;
      end
    end
  end

endmodule

/* rtl/vcdac_palette.sv */
// ----------------------------------------------------------------------------
// vcdac_palette - 256 x 24 palette memory
// Synchronous ram with per-entry valid bits; an entry never written reads
// as the grey ramp value.
// ----------------------------------------------------------------------------
module vcdac_palette import vcdac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pal_wr_t     pal_wr,
  input  pal_rd_t     pal_rd,
  output logic [23:0] rgb
);

  logic [23:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] entry_valid;
  logic [23:0]              rd_q;
  logic                     rd_valid_q;
  logic [PAL_AW-1:0]        rd_addr_q;
  logic [23:0]              fill_word;
  logic [7:0]               grey_w;
  logic [7:0]               grey_r;

  assign grey_w = 8'(pal_wr.addr);
  assign grey_r = 8'(rd_addr_q);

  // first write to an entry stores the whole word, grey in the other lanes
  always_comb begin
    fill_word = {grey_w, grey_w, grey_w};
    case (pal_wr.lane)
      LANE_RED:   fill_word[23:16] = pal_wr.data;
      LANE_GREEN: fill_word[15:8]  = pal_wr.data;
      default:    fill_word[7:0]   = pal_wr.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pal_wr.en) begin
      if (!entry_valid[pal_wr.addr]) begin
        mem[pal_wr.addr] <= fill_word;
      end else begin
        case (pal_wr.lane)
          LANE_RED:   mem[pal_wr.addr][23:16] <= pal_wr.data;
          LANE_GREEN: mem[pal_wr.addr][15:8]  <= pal_wr.data;
          default:    mem[pal_wr.addr][7:0]   <= pal_wr.data;
        endcase
      end
    end
    if (pal_rd.en) begin
      rd_q      <= mem[pal_rd.addr];
      rd_addr_q <= pal_rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (pal_wr.en) entry_valid[pal_wr.addr] <= 1'b1;
      if (pal_rd.en) rd_valid_q <= entry_valid[pal_rd.addr];
    end
  end

  assign rgb = rd_valid_q ? rd_q : {grey_r, grey_r, grey_r};

endmodule

/* rtl/video_control_and_palette_dac.sv */
// ----------------------------------------------------------------------------
// video_control_and_palette_dac - video controller registers and palette dac
// Bus register accesses to the control and dac registers, plus pixel colour
// lookup through a 256-entry rgb palette.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_word carry one operation per word: control read or
//   write, dac read or write, or a pixel lookup. A word is taken on a rising
//   edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_word return exactly one result word per input
//   word, in order, in the cycle after it was taken. A new word is
//   taken every cycle while the output is drained, since the output register
//   frees as it empties; the palette ram read port is used once per lookup.
//   The geometry fields describe the state after the word's action.
//   When out_stall is high with a result held, in_stall rises and the result
//   and palette read data hold until taken.
//   cfg_wr_en/cfg_wr_data write the 3-bit monitor sense code.
//   rst (synchronous) restores all registers: mode 0x9f, depth 0, drive 8,
//   sense 6, pointer and component counter 0; all palette entries read as
//   the grey ramp by clearing their valid bits in the same cycle.
// ----------------------------------------------------------------------------
module video_control_and_palette_dac import vcdac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  logic        accept;
  res_t        res;
  res_t        res_q;
  pal_wr_t     pal_wr;
  pal_rd_t     pal_rd;
  logic [23:0] pal_rgb;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  vcdac_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res),
    .pal_wr      (pal_wr),
    .pal_rd      (pal_rd)
  );

  vcdac_palette u_palette (
    .clk    (clk),
    .rst    (rst),
    .pal_wr (pal_wr),
    .pal_rd (pal_rd),
    .rgb    (pal_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res;
  end

  always_comb begin
    out_word.read_data       = res_q.read_data;
    out_word.display_enabled = res_q.display_enabled;
    out_word.frame_width     = res_q.frame_width;
    out_word.frame_height    = res_q.frame_height;
    out_word.bits_per_pixel  = res_q.bits_per_pixel;
    out_word.stride_bytes    = res_q.stride_bytes;
    out_word.pixel_rgb       = res_q.lookup ? pal_rgb : '0;
  end

endmodule

/* tb/sv/tb_video_control_and_palette_dac.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_control_and_palette_dac - video controller and palette dac bench
// Drives control/dac register traffic and pixel lookups under random input
// gaps and output stalls, predicts every result word from a local copy of
// the registers and palette, and compares the words field by field in order.
// ----------------------------------------------------------------------------
module tb_video_control_and_palette_dac;
  import vcdac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 16;
  localparam int REPORT_MAX  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;

  // no idling on either side while set
  bit calm = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;

  // local copy of the block state
  logic [7:0] mode_q;
  logic [2:0] depth_q;
  logic [3:0] drive_q;
  logic       test_q;
  logic [7:0] pal_ptr;
  logic [1:0] lane_cnt;
  logic [7:0] dac_ctrl_q;
  logic [7:0] color_key_q;
  logic [2:0] sense_q;
  logic [7:0] palette [0:PALETTE_DEPTH-1][0:2];

  out_word_t awaited_status [$];

  video_control_and_palette_dac u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void reset_video_state();
    mode_q      = MODE_RESET;
    depth_q     = DEPTH_1BPP;
    drive_q     = DRIVE_RESET;
    test_q      = 1'b0;
    pal_ptr     = '0;
    lane_cnt    = LANE_RED;
    dac_ctrl_q  = '0;
    color_key_q = '0;
    sense_q     = SENSE_RESET;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      palette[i][LANE_RED]   = 8'(i);
      palette[i][LANE_GREEN] = 8'(i);
      palette[i][LANE_BLUE]  = 8'(i);
    end
  endfunction

  // applies one operation to the local state and returns its status word
  function automatic out_word_t apply_video_op(input in_word_t w);
    out_word_t  r;
    logic [2:0] s;
    logic [7:0] idx;
    logic       known;
    logic       deep;
    int         wd;
    int         ht;
    int         bpp;
    r = '0;
    case (w.action)
      ACT_CTRL_RD: begin
        case (w.reg_offset)
          CTRL_MODE:    r.read_data = mode_q;
          CTRL_DEPTH:   r.read_data = {5'b0, depth_q};
          CTRL_MONITOR: begin
            s = sense_q;
            // sense lines only follow drive bits when drive bit 3 is clear
            if (!drive_q[3]) s = s & drive_q[2:0];
            r.read_data = {1'b0, s, drive_q};
          end
          CTRL_TEST:    r.read_data = {7'b0, test_q};
          default:      r.read_data = '0;
        endcase
      end
      ACT_CTRL_WR: begin
        case (w.reg_offset)
          CTRL_MODE:    mode_q = w.write_data & MODE_MASK;
          CTRL_DEPTH:   depth_q = w.write_data[2:0];
          CTRL_MONITOR: drive_q = w.write_data[3:0] & DRIVE_MASK;
          CTRL_TEST:    test_q = w.write_data[0];
          default: ;
        endcase
      end
      ACT_DAC_RD: begin
        if (w.reg_offset[1:0] == DAC_CTRL) r.read_data = dac_ctrl_q;
      end
      ACT_DAC_WR: begin
        case (w.reg_offset[1:0])
          DAC_ADDR: begin
            pal_ptr  = w.write_data;
            lane_cnt = LANE_RED;
          end
          DAC_DATA: begin
            palette[pal_ptr][lane_cnt] = w.write_data;
            if (lane_cnt == LANE_BLUE) begin
              lane_cnt = LANE_RED;
              pal_ptr  = pal_ptr + 8'd1;
            end else begin
              lane_cnt = lane_cnt + 2'd1;
            end
          end
          DAC_CTRL: dac_ctrl_q = w.write_data;
          DAC_KEY:  color_key_q = w.write_data;
        endcase
      end
      default: ;
    endcase

    known = 1'b1;
    deep  = 1'b0;
    wd    = 0;
    ht    = 0;
    case (mode_q[4:0])
      MODE_512X384:     begin wd = 512; ht = 384; deep = 1'b1; end
      MODE_640X480:     begin wd = 640; ht = 480; deep = 1'b1; end
      MODE_640X870:     begin wd = 640; ht = 870; end
      MODE_832X624:     begin wd = 832; ht = 624; end
      MODE_640X480_LOW: begin wd = 640; ht = 480; end
      default:          known = 1'b0;
    endcase

    if (known && !mode_q[7] &&
        (depth_q < DEPTH_16BPP || (depth_q == DEPTH_16BPP && deep))) begin
      bpp = 1 << depth_q;
      r.display_enabled = 1'b1;
      r.frame_width     = 10'(wd);
      r.frame_height    = 10'(ht);
      r.bits_per_pixel  = 5'(bpp);
      r.stride_bytes    = 11'((wd * bpp + 7) / 8);
      if (w.action == ACT_LOOKUP && depth_q != DEPTH_16BPP) begin
        case (depth_q)
          DEPTH_1BPP: idx = w.pixel_value[0] ? 8'd127 : 8'd255;
          DEPTH_2BPP: idx = {w.pixel_value[1:0], 6'h3f};
          DEPTH_4BPP: idx = {w.pixel_value[3:0], 4'hf};
          default:    idx = w.pixel_value;
        endcase
        r.pixel_rgb = {palette[idx][LANE_RED], palette[idx][LANE_GREEN],
                       palette[idx][LANE_BLUE]};
      end
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
  endfunction

  function automatic void check_status(input out_word_t got);
    out_word_t want;
    if (awaited_status.size() == 0) begin
      note_mismatch("unexpected word", 0, int'(got));
    end else begin
      want = awaited_status.pop_front();
      if (got.read_data != want.read_data)
        note_mismatch("read_data", want.read_data, got.read_data);
      if (got.display_enabled != want.display_enabled)
        note_mismatch("display_enabled", want.display_enabled, got.display_enabled);
      if (got.frame_width != want.frame_width)
        note_mismatch("frame_width", want.frame_width, got.frame_width);
      if (got.frame_height != want.frame_height)
        note_mismatch("frame_height", want.frame_height, got.frame_height);
      if (got.bits_per_pixel != want.bits_per_pixel)
        note_mismatch("bits_per_pixel", want.bits_per_pixel, got.bits_per_pixel);
      if (got.stride_bytes != want.stride_bytes)
        note_mismatch("stride_bytes", want.stride_bytes, got.stride_bytes);
      if (got.pixel_rgb != want.pixel_rgb)
        note_mismatch("pixel_rgb", want.pixel_rgb, got.pixel_rgb);
    end
  endfunction

  function automatic void queue_status(input out_word_t w);
    awaited_status = {awaited_status, w};
  endfunction

  // predicts at input handshakes, checks at output handshakes
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      cycle_count++;
      if (rst) begin
        reset_video_state();
      end else begin
        if (out_valid && !out_stall) check_status(out_word);
        if (in_valid && !in_stall) queue_status(apply_video_op(in_word));
        if (cfg_wr_en) sense_q = cfg_wr_data;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic send_word(input logic [2:0] act, input logic [2:0] off,
                           input logic [7:0] data, input logic [7:0] pix);
    in_word_t w;
    w = '{action: act, reg_offset: off, write_data: data, pixel_value: pix};
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_monitor_sense(input logic [2:0] code);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_word(ACT_CTRL_RD, CTRL_MODE, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_DEPTH, 8'hff, 8'hff);
    send_word(ACT_CTRL_RD, CTRL_MONITOR, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_TEST, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, 3'd7, 8'h00, 8'h00);
    send_word(ACT_DAC_RD, {1'b1, DAC_CTRL}, 8'h00, 8'h00);
    // blanked unknown mode: lookup returns nothing
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'hff);
  endtask

  task automatic test_control_writes();
    send_word(ACT_CTRL_WR, CTRL_MODE, 8'hff, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_DEPTH, 8'hff, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_MONITOR, 8'hf5, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_TEST, 8'hff, 8'h00);
    send_word(ACT_CTRL_WR, 3'd5, 8'hff, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_MODE, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_DEPTH, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_MONITOR, 8'h00, 8'h00);
    send_word(ACT_CTRL_RD, CTRL_TEST, 8'h00, 8'h00);
    for (int k = 1; k <= 3; k++) send_word(3'(ACT_LOOKUP + k), 3'd7, 8'hff, 8'hff);
  endtask

  task automatic test_palette_and_modes();
    // last entry, three lanes, then the pointer wraps to zero
    send_word(ACT_DAC_WR, {1'b0, DAC_ADDR}, 8'hff, 8'h00);
    send_word(ACT_DAC_WR, {1'b0, DAC_DATA}, 8'haa, 8'h00);
    send_word(ACT_DAC_WR, {1'b1, DAC_DATA}, 8'h55, 8'h00);
    send_word(ACT_DAC_WR, {1'b0, DAC_DATA}, 8'h00, 8'h00);
    send_word(ACT_DAC_WR, {1'b0, DAC_DATA}, 8'h12, 8'h00);
    send_word(ACT_DAC_WR, {1'b0, DAC_CTRL}, 8'hff, 8'h00);
    send_word(ACT_DAC_WR, {1'b0, DAC_KEY}, 8'hff, 8'h00);
    send_word(ACT_DAC_RD, {1'b0, DAC_CTRL}, 8'h00, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_MODE, {3'b011, MODE_640X480}, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_DEPTH, {5'b0, DEPTH_1BPP}, 8'h00);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'h00);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'h01);
    send_word(ACT_CTRL_WR, CTRL_DEPTH, {5'b0, DEPTH_8BPP}, 8'h00);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'hff);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_DEPTH, {5'b0, DEPTH_16BPP}, 8'h00);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'h7f);
    // direct depth is not allowed in a low depth mode
    send_word(ACT_CTRL_WR, CTRL_MODE, {3'b000, MODE_832X624}, 8'h00);
    send_word(ACT_CTRL_WR, CTRL_DEPTH, {5'b0, DEPTH_4BPP}, 8'h00);
    send_word(ACT_LOOKUP, 3'd0, 8'h00, 8'h0a);
  endtask

  task automatic test_monitor_sense();
    logic [2:0] codes [3];
    codes = '{3'd0, 3'd7, 3'd3};
    foreach (codes[i]) begin
      set_monitor_sense(codes[i]);
      send_word(ACT_CTRL_WR, CTRL_MONITOR, 8'h08, 8'h00);
      send_word(ACT_CTRL_RD, CTRL_MONITOR, 8'h00, 8'h00);
      send_word(ACT_CTRL_WR, CTRL_MONITOR, 8'h05, 8'h00);
      send_word(ACT_CTRL_RD, CTRL_MONITOR, 8'h00, 8'h00);
    end
  endtask

  function automatic logic [4:0] pick_mode_id();
    case ($urandom_range(0, 5))
      0:       return MODE_512X384;
      1:       return MODE_640X480;
      2:       return MODE_640X870;
      3:       return MODE_832X624;
      4:       return MODE_640X480_LOW;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [2:0] act;
    logic [2:0] off;
    logic [7:0] data;
    int         r;
    for (int phase = 0; phase < 4; phase++) begin
      set_monitor_sense(3'($urandom_range(0, 7)));
      calm = (phase == 2);
      for (int n = 0; n < 375; n++) begin
        r    = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        off  = 3'($urandom_range(0, 7));
        if (r < 35) begin
          act = ACT_LOOKUP;
        end else if (r < 60) begin
          act = ACT_DAC_WR;
          if ($urandom_range(0, 99) < 60) off[1:0] = DAC_DATA;
          else if ($urandom_range(0, 99) < 40) off[1:0] = DAC_ADDR;
        end else if (r < 72) begin
          act = ACT_CTRL_WR;
          if ($urandom_range(0, 9) != 0) off = 3'($urandom_range(0, 3));
          if (off == CTRL_MODE) begin
            data[4:0] = pick_mode_id();
            data[7]   = ($urandom_range(0, 9) == 0);
          end else if (off == CTRL_DEPTH && $urandom_range(0, 9) != 0) begin
            data[2:0] = 3'($urandom_range(0, 4));
          end
        end else if (r < 80) begin
          act = ACT_CTRL_RD;
        end else if (r < 88) begin
          act = ACT_DAC_RD;
        end else begin
          act = 3'($urandom_range(0, 7));
        end
        send_word(act, off, data, 8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_control_writes();
    test_palette_and_modes();
    test_monitor_sense();
    test_random_traffic();
    wait_for_drain();
    if (mismatch_count == 0 && awaited_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* video_control_and_palette_dac.f */
rtl/vcdac_pkg.sv
rtl/vcdac_regs.sv
rtl/vcdac_palette.sv
rtl/video_control_and_palette_dac.sv
tb/sv/tb_video_control_and_palette_dac.sv
